// File: hw/rtl/climate_hysteresis_relay_controller_top_defines.svh
// assertion macros used by the climate relay controller top rtl
`ifndef CLIMATE_HYSTERESIS_RELAY_CONTROLLER_TOP_DEFINES_SVH
`define CLIMATE_HYSTERESIS_RELAY_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CHRC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CHRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/chrc_pkg.sv
// types, codes and reset values for the climate relay controller
package chrc_pkg;

    localparam logic [6:0] LIMIT_MAX         = 7'd99;
    localparam logic [6:0] TEMP_LIMIT_RESET  = 7'd35;
    localparam logic [6:0] HUMID_LIMIT_RESET = 7'd70;
    localparam logic [6:0] GAS_LIMIT_RESET   = 7'd6;

    localparam logic CMD_KEY    = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [2:0] KEY_NONE  = 3'd0;
    localparam logic [2:0] KEY_MENU  = 3'd1;
    localparam logic [2:0] KEY_UP    = 3'd2;
    localparam logic [2:0] KEY_DOWN  = 3'd3;
    localparam logic [2:0] KEY_ENTER = 3'd4;

    localparam logic [1:0] ALARM_NORMAL  = 2'd0;
    localparam logic [1:0] ALARM_ACTIVE  = 2'd1;
    localparam logic [1:0] ALARM_PREHEAT = 2'd2;

    typedef enum logic [2:0] {
        SCREEN_HOME   = 3'd0,
        SCREEN_TEMP   = 3'd1,
        SCREEN_HUMID  = 3'd2,
        SCREEN_GAS    = 3'd3,
        SCREEN_MANUAL = 3'd4
    } t_screen;

    typedef struct packed {
        logic               command;
        logic [2:0]         key_number;
        logic signed [11:0] temperature_tenths;
        logic [9:0]         humidity_tenths;
        logic [13:0]        gas_thousandths;
        logic               preheating;
    } t_item;

    // relay bit order: bit0 dehumidifier, bit1 sterilizer, bit2 fan
    typedef struct packed {
        t_screen    screen;
        logic       manual;
        logic [6:0] temp_limit;
        logic [6:0] humid_limit;
        logic [6:0] gas_limit;
        logic       humid_latch;
        logic       heat_latch;
        logic       gas_latch;
        logic [2:0] relay_drive;
        logic [2:0] auto_relay;
        logic [2:0] manual_relay;
        logic       buzzer;
        logic [1:0] alarm;
    } t_state;

    localparam t_state STATE_RESET = '{
        screen:       SCREEN_HOME,
        manual:       1'b0,
        temp_limit:   TEMP_LIMIT_RESET,
        humid_limit:  HUMID_LIMIT_RESET,
        gas_limit:    GAS_LIMIT_RESET,
        humid_latch:  1'b0,
        heat_latch:   1'b0,
        gas_latch:    1'b0,
        relay_drive:  3'b000,
        auto_relay:   3'b000,
        manual_relay: 3'b000,
        buzzer:       1'b0,
        alarm:        ALARM_NORMAL
    };

    typedef struct packed {
        logic [2:0] relay;
        logic       buzzer;
        logic [1:0] alarm;
        logic [2:0] screen;
        logic       manual;
        logic       save;
        logic [6:0] temp_limit;
        logic [6:0] humid_limit;
        logic [6:0] gas_limit;
    } t_result;

endpackage

// File: hw/rtl/chrc_eval.sv
// next-state logic for one key press or sensor sample
module chrc_eval (
    input  chrc_pkg::t_state i_state,
    input  chrc_pkg::t_item  i_item,
    output chrc_pkg::t_state o_state,
    output logic             o_save
);

    logic [9:0]         hl10;
    logic [9:0]         tl10;
    logic [9:0]         gl10;
    logic [9:0]         gclr10;
    logic signed [13:0] t14;
    logic signed [13:0] tl14;
    logic [1:0]         bit_idx;
    logic [2:0]         bit_mask;
    logic [2:0]         toggled;
    logic               hum_n;
    logic               heat_n;
    logic               gas_n;
    logic [2:0]         relays;
    logic               any_latch;

    // limits times ten, shift-add
    assign hl10 = {i_state.humid_limit, 3'b000} + {2'b00, i_state.humid_limit, 1'b0};
    assign tl10 = {i_state.temp_limit, 3'b000} + {2'b00, i_state.temp_limit, 1'b0};
    assign gl10 = {i_state.gas_limit, 3'b000} + {2'b00, i_state.gas_limit, 1'b0};
    assign gclr10 = (i_state.gas_limit != 7'd0) ? (gl10 - 10'd10) : 10'd0;

    assign t14  = 14'($signed(i_item.temperature_tenths));
    assign tl14 = $signed({4'b0000, tl10});

    // keys 2..4 select relay bits 0..2
    assign bit_idx  = 2'(i_item.key_number[1:0] - 2'd2);
    assign bit_mask = 3'b001 << bit_idx;
    assign toggled  = i_state.manual_relay ^ bit_mask;

    always_comb begin
        if ({1'b0, i_item.humidity_tenths} > {1'b0, hl10}) begin
            hum_n = 1'b1;
        end else if (({1'b0, i_item.humidity_tenths} + 11'd20) <= {1'b0, hl10}) begin
            hum_n = 1'b0;
        end else begin
            hum_n = i_state.humid_latch;
        end

        if (t14 > tl14) begin
            heat_n = 1'b1;
        end else if ((t14 + 14'sd10) <= tl14) begin
            heat_n = 1'b0;
        end else begin
            heat_n = i_state.heat_latch;
        end

        if (i_item.preheating) begin
            gas_n = 1'b0;
        end else if (i_item.gas_thousandths >= {4'b0000, gl10}) begin
            gas_n = 1'b1;
        end else if (i_item.gas_thousandths <= {4'b0000, gclr10}) begin
            gas_n = 1'b0;
        end else begin
            gas_n = i_state.gas_latch;
        end

        relays    = {heat_n | gas_n, gas_n, hum_n};
        any_latch = hum_n | heat_n | gas_n;
    end

    always_comb begin
        o_state = i_state;
        o_save  = 1'b0;
        if (i_item.command == chrc_pkg::CMD_KEY) begin
            if (i_item.key_number == chrc_pkg::KEY_ENTER
                    && i_state.screen == chrc_pkg::SCREEN_HOME) begin
                o_state.screen       = chrc_pkg::SCREEN_MANUAL;
                o_state.manual       = 1'b1;
                o_state.manual_relay = i_state.auto_relay;
                o_state.buzzer       = 1'b0;
            end else if (i_item.key_number == chrc_pkg::KEY_ENTER
                    && i_state.screen != chrc_pkg::SCREEN_MANUAL) begin
                o_save         = 1'b1;
                o_state.screen = chrc_pkg::SCREEN_HOME;
            end else if (i_item.key_number != chrc_pkg::KEY_NONE
                    && i_item.key_number <= chrc_pkg::KEY_ENTER) begin
                if (i_state.screen == chrc_pkg::SCREEN_MANUAL) begin
                    if (i_item.key_number == chrc_pkg::KEY_MENU) begin
                        // relays and buzzer keep their levels
                        o_state.screen = chrc_pkg::SCREEN_HOME;
                        o_state.manual = 1'b0;
                    end else begin
                        o_state.manual_relay = toggled;
                        o_state.relay_drive  = (i_state.relay_drive & ~bit_mask)
                                             | (toggled & bit_mask);
                    end
                end else begin
                    unique case (i_item.key_number)
                        chrc_pkg::KEY_MENU: begin
                            unique case (i_state.screen)
                                chrc_pkg::SCREEN_HOME:  o_state.screen = chrc_pkg::SCREEN_TEMP;
                                chrc_pkg::SCREEN_TEMP:  o_state.screen = chrc_pkg::SCREEN_HUMID;
                                chrc_pkg::SCREEN_HUMID: o_state.screen = chrc_pkg::SCREEN_GAS;
                                default:                o_state.screen = chrc_pkg::SCREEN_HOME;
                            endcase
                        end
                        chrc_pkg::KEY_UP: begin
                            if (i_state.screen == chrc_pkg::SCREEN_TEMP
                                    && i_state.temp_limit < chrc_pkg::LIMIT_MAX) begin
                                o_state.temp_limit = i_state.temp_limit + 7'd1;
                            end
                            if (i_state.screen == chrc_pkg::SCREEN_HUMID
                                    && i_state.humid_limit < chrc_pkg::LIMIT_MAX) begin
                                o_state.humid_limit = i_state.humid_limit + 7'd1;
                            end
                            if (i_state.screen == chrc_pkg::SCREEN_GAS
                                    && i_state.gas_limit < chrc_pkg::LIMIT_MAX) begin
                                o_state.gas_limit = i_state.gas_limit + 7'd1;
                            end
                        end
                        chrc_pkg::KEY_DOWN: begin
                            if (i_state.screen == chrc_pkg::SCREEN_TEMP
                                    && i_state.temp_limit > 7'd1) begin
                                o_state.temp_limit = i_state.temp_limit - 7'd1;
                            end
                            if (i_state.screen == chrc_pkg::SCREEN_HUMID
                                    && i_state.humid_limit > 7'd1) begin
                                o_state.humid_limit = i_state.humid_limit - 7'd1;
                            end
                            if (i_state.screen == chrc_pkg::SCREEN_GAS
                                    && i_state.gas_limit > 7'd0) begin
                                o_state.gas_limit = i_state.gas_limit - 7'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end else if (!i_state.manual) begin
            o_state.humid_latch = hum_n;
            o_state.heat_latch  = heat_n;
            o_state.gas_latch   = gas_n;
            o_state.relay_drive = relays;
            o_state.auto_relay  = relays;
            o_state.buzzer      = any_latch;
            o_state.alarm       = any_latch ? chrc_pkg::ALARM_ACTIVE
                                : (i_item.preheating ? chrc_pkg::ALARM_PREHEAT
                                                     : chrc_pkg::ALARM_NORMAL);
        end
    end

endmodule

// File: hw/rtl/climate_hysteresis_relay_controller_top.sv
// climate relay controller: menu keys, limit editing and hysteresis relay drive
//
// input channel: i_valid / o_stall with one key press (command 0) or one
// sensor sample (command 1) per beat. output channel: o_valid / i_stall,
// exactly one result beat per input beat, in order, holding the relay,
// buzzer, alarm, screen and limit state after that event plus a one-beat
// save request.
// each beat passes one input register, then the next-state logic
// writes the state registers and the output register together.
// throughput is one beat per cycle when not stalled; the state loop closes
// through compare and select logic, so each beat sees the prior beat's state.
// when the receiver stalls, the result stays in the output register and one
// more beat waits in the input register; o_stall rises only when both are
// full and the output is not taken.
// reset (synchronous, active low) empties both registers, sets the limits to
// 35, 70 and 6, the home screen, automatic mode and all relays off.
`include "climate_hysteresis_relay_controller_top_defines.svh"

module climate_hysteresis_relay_controller_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic [2:0]         i_key_number,
    input  logic signed [11:0] i_temperature_tenths,
    input  logic [9:0]         i_humidity_tenths,
    input  logic [13:0]        i_gas_thousandths,
    input  logic               i_preheating,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_dehumidifier_on,
    output logic               o_sterilizer_on,
    output logic               o_fan_on,
    output logic               o_buzzer_on,
    output logic [1:0]         o_alarm_status,
    output logic [2:0]         o_screen,
    output logic               o_manual_active,
    output logic               o_save_pulse,
    output logic [6:0]         o_temperature_limit,
    output logic [6:0]         o_humidity_limit,
    output logic [6:0]         o_gas_limit
);

    logic              r_in_vld;
    chrc_pkg::t_item   r_in;
    chrc_pkg::t_state  r_state;
    chrc_pkg::t_state  n_state;
    logic              n_save;
    logic              r_out_vld;
    chrc_pkg::t_result r_out;
    logic              move;
    logic              accept;

    assign move    = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !move;
    assign accept  = i_valid && !o_stall;

    chrc_eval u_eval (
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_save  (n_save)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= chrc_pkg::STATE_RESET;
        end else begin
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (move) begin
                r_in_vld <= 1'b0;
            end
            if (move) begin
                r_state   <= n_state;
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= '{
                command:            i_command,
                key_number:         i_key_number,
                temperature_tenths: i_temperature_tenths,
                humidity_tenths:    i_humidity_tenths,
                gas_thousandths:    i_gas_thousandths,
                preheating:         i_preheating
            };
        end
        if (move) begin
            r_out <= '{
                relay:       n_state.relay_drive,
                buzzer:      n_state.buzzer,
                alarm:       n_state.alarm,
                screen:      n_state.screen,
                manual:      n_state.manual,
                save:        n_save,
                temp_limit:  n_state.temp_limit,
                humid_limit: n_state.humid_limit,
                gas_limit:   n_state.gas_limit
            };
        end
    end

    assign o_valid             = r_out_vld;
    assign o_dehumidifier_on   = r_out.relay[0];
    assign o_sterilizer_on     = r_out.relay[1];
    assign o_fan_on            = r_out.relay[2];
    assign o_buzzer_on         = r_out.buzzer;
    assign o_alarm_status      = r_out.alarm;
    assign o_screen            = r_out.screen;
    assign o_manual_active     = r_out.manual;
    assign o_save_pulse        = r_out.save;
    assign o_temperature_limit = r_out.temp_limit;
    assign o_humidity_limit    = r_out.humid_limit;
    assign o_gas_limit         = r_out.gas_limit;

    `CHRC_ASSERT_SAME(a_manual_screen, o_valid, o_manual_active == (o_screen == 3'(chrc_pkg::SCREEN_MANUAL)), "manual flag and manual screen disagree")
    `CHRC_ASSERT_SAME(a_save_home, o_valid && o_save_pulse, o_screen == 3'(chrc_pkg::SCREEN_HOME) && !o_manual_active, "save beat not on home screen")
    `CHRC_ASSERT_SAME(a_limit_range, 1'b1, r_state.temp_limit >= 7'd1 && r_state.temp_limit <= chrc_pkg::LIMIT_MAX && r_state.humid_limit >= 7'd1 && r_state.humid_limit <= chrc_pkg::LIMIT_MAX && r_state.gas_limit <= chrc_pkg::LIMIT_MAX, "limit out of range")
    `CHRC_ASSERT_NEXT(a_manual_ignores_sample, move && r_in.command == chrc_pkg::CMD_SAMPLE && r_state.manual, r_state == $past(r_state), "sample changed state in manual mode")

endmodule

// File: bench/climate_relay_result_checker.sv
// result checker for the climate relay controller: predicts every beat and compares it
`timescale 1ns / 100ps

module climate_relay_result_checker
    import chrc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_command,
    input  logic [2:0]         i_key_number,
    input  logic signed [11:0] i_temperature_tenths,
    input  logic [9:0]         i_humidity_tenths,
    input  logic [13:0]        i_gas_thousandths,
    input  logic               i_preheating,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_dehumidifier_on,
    input  logic               i_sterilizer_on,
    input  logic               i_fan_on,
    input  logic               i_buzzer_on,
    input  logic [1:0]         i_alarm_status,
    input  logic [2:0]         i_screen,
    input  logic               i_manual_active,
    input  logic               i_save_pulse,
    input  logic [6:0]         i_temperature_limit,
    input  logic [6:0]         i_humidity_limit,
    input  logic [6:0]         i_gas_limit,
    output int                 o_pending,
    output int                 o_fail_count
);

    localparam int         REPORT_MAX    = 10;
    localparam int         TENTHS        = 10;
    localparam int         HUMID_BAND    = 20;
    localparam int         TEMP_BAND     = 10;
    localparam int         GAS_BAND      = 10;
    localparam logic [6:0] TH_LIMIT_MIN  = 7'd1;
    localparam logic [6:0] GAS_LIMIT_MIN = 7'd0;

    // controller state as the predictor sees it
    t_screen    screen_q;
    logic       manual_q;
    logic [6:0] temp_lim;
    logic [6:0] humid_lim;
    logic [6:0] gas_lim;
    logic       humid_hold;
    logic       heat_hold;
    logic       gas_hold;
    logic [2:0] relay_q;
    logic [2:0] auto_relay_q;
    logic [2:0] manual_relay_q;
    logic       buzzer_q;
    logic [1:0] alarm_q;

    t_result predicted_status [$];
    int      mismatches = 0;

    function automatic t_result apply_event(input t_item ev);
        t_result    res;
        logic       saved;
        logic [2:0] flip;
        logic [2:0] relays;
        logic       any_hold;
        int         t_val;
        int         h_val;
        int         g_val;
        int         t_lim;
        int         h_lim;
        int         g_lim;
        int         g_clear;
        saved = 1'b0;
        if (ev.command == CMD_KEY) begin
            if (screen_q == SCREEN_MANUAL) begin
                case (ev.key_number)
                    KEY_MENU: begin
                        screen_q = SCREEN_HOME;
                        manual_q = 1'b0;
                    end
                    KEY_UP, KEY_DOWN, KEY_ENTER: begin
                        // keys 2..4 map onto relay bits 0..2
                        flip = 3'b001 << (ev.key_number - KEY_UP);
                        manual_relay_q = manual_relay_q ^ flip;
                        relay_q = (relay_q & ~flip) | (manual_relay_q & flip);
                    end
                    default: ;
                endcase
            end else begin
                case (ev.key_number)
                    KEY_MENU: begin
                        screen_q = (screen_q == SCREEN_GAS) ? SCREEN_HOME
                                                            : t_screen'(screen_q + 3'd1);
                    end
                    KEY_UP: begin
                        case (screen_q)
                            SCREEN_TEMP:  if (temp_lim < LIMIT_MAX) temp_lim = temp_lim + 7'd1;
                            SCREEN_HUMID: if (humid_lim < LIMIT_MAX) humid_lim = humid_lim + 7'd1;
                            SCREEN_GAS:   if (gas_lim < LIMIT_MAX) gas_lim = gas_lim + 7'd1;
                            default: ;
                        endcase
                    end
                    KEY_DOWN: begin
                        case (screen_q)
                            SCREEN_TEMP:  if (temp_lim > TH_LIMIT_MIN) temp_lim = temp_lim - 7'd1;
                            SCREEN_HUMID: if (humid_lim > TH_LIMIT_MIN) humid_lim = humid_lim - 7'd1;
                            SCREEN_GAS:   if (gas_lim > GAS_LIMIT_MIN) gas_lim = gas_lim - 7'd1;
                            default: ;
                        endcase
                    end
                    KEY_ENTER: begin
                        if (screen_q == SCREEN_HOME) begin
                            screen_q       = SCREEN_MANUAL;
                            manual_q       = 1'b1;
                            manual_relay_q = auto_relay_q;
                            buzzer_q       = 1'b0;
                        end else begin
                            saved    = 1'b1;
                            screen_q = SCREEN_HOME;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (!manual_q) begin
            t_val = $signed(ev.temperature_tenths);
            h_val = ev.humidity_tenths;
            g_val = ev.gas_thousandths;
            t_lim = int'(temp_lim) * TENTHS;
            h_lim = int'(humid_lim) * TENTHS;
            g_lim = int'(gas_lim) * TENTHS;

            if (h_val > h_lim) humid_hold = 1'b1;
            else if (h_val <= h_lim - HUMID_BAND) humid_hold = 1'b0;

            if (t_val > t_lim) heat_hold = 1'b1;
            else if (t_val <= t_lim - TEMP_BAND) heat_hold = 1'b0;

            // gas trips at the limit itself, and a zero limit trips on every sample outside preheat
            if (ev.preheating) begin
                gas_hold = 1'b0;
            end else begin
                g_clear = (gas_lim != GAS_LIMIT_MIN) ? g_lim - GAS_BAND : 0;
                if (g_val >= g_lim) gas_hold = 1'b1;
                else if (g_val <= g_clear) gas_hold = 1'b0;
            end

            relays       = {heat_hold | gas_hold, gas_hold, humid_hold};
            any_hold     = humid_hold | heat_hold | gas_hold;
            relay_q      = relays;
            auto_relay_q = relays;
            buzzer_q     = any_hold;
            alarm_q      = any_hold ? ALARM_ACTIVE
                         : (ev.preheating ? ALARM_PREHEAT : ALARM_NORMAL);
        end

        res.relay       = relay_q;
        res.buzzer      = buzzer_q;
        res.alarm       = alarm_q;
        res.screen      = screen_q;
        res.manual      = manual_q;
        res.save        = saved;
        res.temp_limit  = temp_lim;
        res.humid_limit = humid_lim;
        res.gas_limit   = gas_lim;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_item   ev;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            screen_q       = SCREEN_HOME;
            manual_q       = 1'b0;
            temp_lim       = TEMP_LIMIT_RESET;
            humid_lim      = HUMID_LIMIT_RESET;
            gas_lim        = GAS_LIMIT_RESET;
            humid_hold     = 1'b0;
            heat_hold      = 1'b0;
            gas_hold       = 1'b0;
            relay_q        = 3'b000;
            auto_relay_q   = 3'b000;
            manual_relay_q = 3'b000;
            buzzer_q       = 1'b0;
            alarm_q        = ALARM_NORMAL;
            predicted_status.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                ev.command            = i_command;
                ev.key_number         = i_key_number;
                ev.temperature_tenths = i_temperature_tenths;
                ev.humidity_tenths    = i_humidity_tenths;
                ev.gas_thousandths    = i_gas_thousandths;
                ev.preheating         = i_preheating;
                predicted_status.push_back(apply_event(ev));
            end
            if (i_out_valid && !i_out_stall) begin
                got.relay       = {i_fan_on, i_sterilizer_on, i_dehumidifier_on};
                got.buzzer      = i_buzzer_on;
                got.alarm       = i_alarm_status;
                got.screen      = i_screen;
                got.manual      = i_manual_active;
                got.save        = i_save_pulse;
                got.temp_limit  = i_temperature_limit;
                got.humid_limit = i_humidity_limit;
                got.gas_limit   = i_gas_limit;
                if (predicted_status.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result beat with nothing outstanding", $time);
                end else begin
                    want = predicted_status.pop_front();
                    if (got.relay !== want.relay || got.buzzer !== want.buzzer ||
                        got.alarm !== want.alarm || got.screen !== want.screen ||
                        got.manual !== want.manual || got.save !== want.save ||
                        got.temp_limit !== want.temp_limit ||
                        got.humid_limit !== want.humid_limit ||
                        got.gas_limit !== want.gas_limit) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("%0t: mismatch, expected relay %b buz %b alarm %0d scr %0d",
                                     $time, want.relay, want.buzzer, want.alarm, want.screen);
                            $display("    man %b save %b limits %0d %0d %0d",
                                     want.manual, want.save, want.temp_limit,
                                     want.humid_limit, want.gas_limit);
                            $display("    actual relay %b buz %b alarm %0d scr %0d",
                                     got.relay, got.buzzer, got.alarm, got.screen);
                            $display("    man %b save %b limits %0d %0d %0d",
                                     got.manual, got.save, got.temp_limit,
                                     got.humid_limit, got.gas_limit);
                        end
                    end
                end
            end
        end
        o_pending    <= predicted_status.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: bench/climate_hysteresis_relay_controller_top_test.sv
// testbench top for the climate relay controller: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module climate_hysteresis_relay_controller_top_test;
    import chrc_pkg::*;

    localparam int         RANDOM_ITEMS  = 2000;
    localparam int         CYCLE_LIMIT   = 1000000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         MENU_SCREENS  = 4;
    localparam logic [2:0] KEY_TOP       = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_command = CMD_KEY;
    logic [2:0]         i_key_number = KEY_NONE;
    logic signed [11:0] i_temperature_tenths = '0;
    logic [9:0]         i_humidity_tenths = '0;
    logic [13:0]        i_gas_thousandths = '0;
    logic               i_preheating = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_dehumidifier_on;
    logic               o_sterilizer_on;
    logic               o_fan_on;
    logic               o_buzzer_on;
    logic [1:0]         o_alarm_status;
    logic [2:0]         o_screen;
    logic               o_manual_active;
    logic               o_save_pulse;
    logic [6:0]         o_temperature_limit;
    logic [6:0]         o_humidity_limit;
    logic [6:0]         o_gas_limit;

    int pending;
    int fail_count;
    int cycle_count = 0;
    int counted_items = 0;
    int stall_left = 0;
    bit valid_up = 1'b0;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    bit in_manual = 1'b0;
    int t_walk = 250;
    int h_walk = 600;
    int g_walk = 40;

    climate_hysteresis_relay_controller_top i_dut (.*);

    climate_relay_result_checker u_check (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_valid),
        .i_in_stall           (o_stall),
        .i_command            (i_command),
        .i_key_number         (i_key_number),
        .i_temperature_tenths (i_temperature_tenths),
        .i_humidity_tenths    (i_humidity_tenths),
        .i_gas_thousandths    (i_gas_thousandths),
        .i_preheating         (i_preheating),
        .i_out_valid          (o_valid),
        .i_out_stall          (i_stall),
        .i_dehumidifier_on    (o_dehumidifier_on),
        .i_sterilizer_on      (o_sterilizer_on),
        .i_fan_on             (o_fan_on),
        .i_buzzer_on          (o_buzzer_on),
        .i_alarm_status       (o_alarm_status),
        .i_screen             (o_screen),
        .i_manual_active      (o_manual_active),
        .i_save_pulse         (o_save_pulse),
        .i_temperature_limit  (o_temperature_limit),
        .i_humidity_limit     (o_humidity_limit),
        .i_gas_limit          (o_gas_limit),
        .o_pending            (pending),
        .o_fail_count         (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** climate_hysteresis_relay_controller_top: FAILED **");
            $finish;
        end
    end

    // mostly short idle stretches, now and then a long one
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int clip(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (stalls_on && $urandom_range(0, 99) < 30) begin
            stall_left = pick_idle_len() - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic drop_valid();
        if (valid_up) begin
            i_valid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    task automatic send_beat(input logic cmd, input logic [2:0] key,
                             input logic signed [11:0] temp, input logic [9:0] humid,
                             input logic [13:0] gas, input logic pre);
        int gap;
        i_valid              <= 1'b1;
        valid_up             = 1'b1;
        i_command            <= cmd;
        i_key_number         <= key;
        i_temperature_tenths <= temp;
        i_humidity_tenths    <= humid;
        i_gas_thousandths    <= gas;
        i_preheating         <= pre;
        do @(posedge i_clk); while (o_stall);
        gap = (gaps_on && $urandom_range(0, 99) >= 55) ? pick_idle_len() : 0;
        if (gap > 0) begin
            drop_valid();
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // key beat with random content in the sample fields
    task automatic send_key_beat(input logic [2:0] key);
        send_beat(CMD_KEY, key, 12'($urandom), 10'($urandom), 14'($urandom), 1'($urandom));
    endtask

    task automatic send_key(input logic [2:0] key);
        send_key_beat(key);
        if (key >= KEY_MENU && key <= KEY_ENTER) counted_items++;
    endtask

    task automatic send_sample(input logic signed [11:0] temp, input logic [9:0] humid,
                               input logic [13:0] gas, input logic pre);
        send_beat(CMD_SAMPLE, 3'($urandom), temp, humid, gas, pre);
        if (!in_manual) counted_items++;
    endtask

    task automatic noise_key();
        logic [2:0] key;
        key = ($urandom_range(0, 3) == 0) ? KEY_NONE
                                          : 3'($urandom_range(KEY_ENTER + 1, KEY_TOP));
        send_key_beat(key);
    endtask

    // random walk so readings linger around the trip and clear points
    task automatic walk_sample();
        if ($urandom_range(0, 15) == 0) begin
            t_walk = int'($urandom_range(0, 1200)) - 100;
            h_walk = $urandom_range(0, 1000);
            g_walk = $urandom_range(0, 1100);
        end else begin
            t_walk = clip(t_walk + int'($urandom_range(0, 30)) - 15, -2048, 2047);
            h_walk = clip(h_walk + int'($urandom_range(0, 30)) - 15, 0, 1023);
            g_walk = clip(g_walk + int'($urandom_range(0, 30)) - 15, 0, 16383);
        end
        send_sample(12'(t_walk), 10'(h_walk), 14'(g_walk), $urandom_range(0, 7) == 0);
    endtask

    task automatic sample_burst();
        int n;
        n = $urandom_range(1, 12);
        repeat (n) walk_sample();
    endtask

    // pick a limit screen, nudge the limit, leave by save or by wrapping the menu
    task automatic edit_limit();
        int         scr;
        int         runs;
        int         len;
        logic [2:0] dir;
        scr  = $urandom_range(1, 3);
        runs = $urandom_range(1, 3);
        repeat (scr) send_key(KEY_MENU);
        repeat (runs) begin
            dir = $urandom_range(0, 1) ? KEY_UP : KEY_DOWN;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 110) : $urandom_range(1, 8);
            repeat (len) send_key(dir);
            if ($urandom_range(0, 3) == 0) walk_sample();
            if ($urandom_range(0, 7) == 0) noise_key();
        end
        if ($urandom_range(0, 1)) send_key(KEY_ENTER);
        else repeat (MENU_SCREENS - scr) send_key(KEY_MENU);
    endtask

    task automatic manual_session();
        int n;
        n = $urandom_range(1, 10);
        send_key(KEY_ENTER);
        in_manual = 1'b1;
        repeat (n) begin
            case ($urandom_range(0, 5))
                0: send_key(KEY_UP);
                1: send_key(KEY_DOWN);
                2: send_key(KEY_ENTER);
                3, 4: walk_sample();
                default: noise_key();
            endcase
        end
        send_key(KEY_MENU);
        in_manual = 1'b0;
    endtask

    task automatic noise_beat();
        case ($urandom_range(0, 3))
            0: noise_key();
            // up and down do nothing on the home screen
            1: send_key_beat($urandom_range(0, 1) ? KEY_UP : KEY_DOWN);
            default: send_sample(12'($urandom), 10'($urandom), 14'($urandom), 1'($urandom));
        endcase
    endtask

    task automatic drain();
        drop_valid();
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        int r;
        int next_phase;
        int phase_idx;
        bit mid_drained;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ignored keys on the home screen
        send_key_beat(KEY_NONE);
        send_key_beat(KEY_TOP);
        send_key_beat(KEY_UP);
        // trip all three, hold inside the bands, then clear exactly at the clear points
        send_sample(12'sd351, 10'd701, 14'd60, 1'b0);
        send_sample(12'sd350, 10'd700, 14'd51, 1'b0);
        send_sample(12'sd340, 10'd680, 14'd50, 1'b0);
        // preheat forces gas clear even far above the limit
        send_sample(12'sd0, 10'd0, 14'd16383, 1'b1);
        send_sample(-12'sd2048, 10'd1023, 14'd0, 1'b0);
        send_sample(12'sd2047, 10'd0, 14'd0, 1'b0);
        // manual mode: samples ignored, each relay toggled, then back to auto
        send_key(KEY_ENTER);
        in_manual = 1'b1;
        send_sample(12'sd0, 10'd1000, 14'd9999, 1'b0);
        send_key(KEY_UP);
        send_key(KEY_DOWN);
        send_key(KEY_ENTER);
        noise_key();
        send_key(KEY_MENU);
        in_manual = 1'b0;
        // walk the limit screens, edit each, save from the gas screen
        send_key(KEY_MENU);
        send_key(KEY_UP);
        send_key(KEY_MENU);
        send_key(KEY_DOWN);
        send_key(KEY_MENU);
        send_key(KEY_DOWN);
        send_key(KEY_ENTER);
        repeat (MENU_SCREENS) send_key(KEY_MENU);
        drain();

        counted_items = 0;
        next_phase    = 0;
        phase_idx     = 0;
        mid_drained   = 1'b0;
        while (counted_items < RANDOM_ITEMS) begin
            if (counted_items >= next_phase) begin
                r          = phase_idx % 4;
                gaps_on    = r[0];
                stalls_on  = r[1];
                phase_idx++;
                next_phase = counted_items + $urandom_range(150, 300);
            end
            if (!mid_drained && counted_items >= RANDOM_ITEMS / 2) begin
                drain();
                mid_drained = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 45) sample_burst();
            else if (r < 70) edit_limit();
            else if (r < 85) manual_session();
            else noise_beat();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** climate_hysteresis_relay_controller_top: PASSED **");
        end else begin
            $display("** climate_hysteresis_relay_controller_top: FAILED **");
        end
        $finish;
    end

endmodule

// File: climate_hysteresis_relay_controller_top.f
+incdir+hw/rtl
hw/rtl/chrc_pkg.sv
hw/rtl/chrc_eval.sv
hw/rtl/climate_hysteresis_relay_controller_top.sv
bench/climate_relay_result_checker.sv
bench/climate_hysteresis_relay_controller_top_test.sv
